### hw/rtl/euclid_gcd_step_count_top_defines.svh
// Assertion macros for the Euclid GCD step counter.
// Used by the top level only; needs clk_i and rst_ni in scope where expanded.
`ifndef EUCLID_GCD_STEP_COUNT_TOP_DEFINES_SVH
`define EUCLID_GCD_STEP_COUNT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define EGSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising clock edge out of reset.
`define EGSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EGSC_ASSERT_NOW(lbl, ante, cons, msg)
`define EGSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/egsc_pkg.sv
// Shared types and constants for the Euclid GCD step counter.
// No dependencies.
package egsc_pkg;

  // Operand width and derived widths.
  localparam int unsigned OperandWidth = 31;
  localparam int unsigned CountWidth   = 6;
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam int unsigned IterWidth    = (OperandWidth > 1) ? $clog2(OperandWidth) : 1;

  typedef logic [OperandWidth-1:0] operand_t;
  typedef logic [CountWidth-1:0]   count_t;

  // Input transaction.
  typedef struct packed {
    operand_t first_value;
    operand_t second_value;
  } egsc_in_t;

  // Result transaction.
  typedef struct packed {
    operand_t divisor;
    count_t   modulo_count;
  } egsc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_start;
    logic step;
  } egsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic small_zero;
    logic div_done;
    logic rem_zero;
  } egsc_stat_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } egsc_state_e;

endpackage

### hw/rtl/euclid_gcd_step_count_top.sv
// Top level of the Euclid GCD step counter: controller plus datapath.
// Depends on egsc_pkg, egsc_ctrl, egsc_dp and the assertion macro header.
//
// Channel   Ports                         Transaction taken when
// input     start, busy, operands_i       start high and busy low at a rising edge
// result    done_o, result_o              done_o high (one cycle, no back-pressure)
//
// Each Euclid round is a check in ST_CHECK, a run of the bit-serial remainder unit and
// an update of the operands; when an operand is zero no round is run. 31-bit operands
// need up to 44 rounds.
// busy stays high from acceptance until the cycle after the result strobe.
// Reset clears the controller and the remainder unit's sequencing only.
// The result receiver cannot stall; done_o marks the result for one cycle only.
`include "euclid_gcd_step_count_top_defines.svh"

module euclid_gcd_step_count_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  egsc_pkg::egsc_in_t  operands_i,
  output logic                done_o,
  output egsc_pkg::egsc_out_t result_o
);
  import egsc_pkg::*;

  egsc_cmd_t  cmd;
  egsc_stat_t stat;

  // Sequencing.
  egsc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Operand registers and remainder unit.
  egsc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .operands_i (operands_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .result_o   (result_o)
  );

  // An accepted transaction makes the block busy in the next cycle.
  `EGSC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  // After the result strobe the block is free again.
  `EGSC_ASSERT_NEXT(a_done_frees, done_o, !busy, "block still busy after result strobe")
  // A remainder run is only started while the datapath is not in a step.
  `EGSC_ASSERT_NOW(a_cmd_excl, cmd.div_start, !cmd.step && !cmd.load, "conflicting commands")

endmodule

### hw/rtl/egsc_rem.sv
// Sequential remainder unit: restoring division, one dividend bit per cycle.
// Depends on egsc_pkg.
module egsc_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  egsc_pkg::operand_t dividend_i,
  input  egsc_pkg::operand_t divisor_i,
  output logic               done_o,
  output egsc_pkg::operand_t remainder_o
);
  import egsc_pkg::*;

  localparam logic [IterWidth-1:0] LastIter = IterWidth'(OperandWidth - 1);

  logic                   run_q;
  logic                   done_q;
  logic [IterWidth-1:0]   iter_q;
  operand_t               dvd_q;
  operand_t               dvs_q;
  operand_t               rem_q;
  operand_t               rem_d;
  logic [OperandWidth:0]  trial;
  logic [OperandWidth:0]  diff;

  // Shift the next dividend bit in and subtract the divisor when it fits.
  always_comb begin
    trial = {rem_q, dvd_q[OperandWidth-1]};
    diff  = trial - {1'b0, dvs_q};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = diff[OperandWidth-1:0];
    end else begin
      rem_d = trial[OperandWidth-1:0];
    end
  end

  // Iteration control: one run of OperandWidth steps per start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      iter_q <= '0;
    end else if (run_q) begin
      iter_q <= iter_q + 1'b1;
      if (iter_q == LastIter) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[OperandWidth-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

### hw/rtl/egsc_dp.sv
// Datapath: operand registers, round counter and the shared remainder unit.
// Depends on egsc_pkg and egsc_rem.
module egsc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  egsc_pkg::egsc_in_t  operands_i,
  input  egsc_pkg::egsc_cmd_t cmd_i,
  output egsc_pkg::egsc_stat_t stat_o,
  output egsc_pkg::egsc_out_t result_o
);
  import egsc_pkg::*;

  operand_t big_q;
  operand_t small_q;
  count_t   count_q;
  operand_t remainder;
  logic     div_done;
  logic     rem_zero;

  // Remainder of big by small.
  egsc_rem u_rem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (big_q),
    .divisor_i   (small_q),
    .done_o      (div_done),
    .remainder_o (remainder)
  );

  assign rem_zero = (remainder == '0);

  // Load with the larger operand first; each round counts and moves down.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (operands_i.first_value < operands_i.second_value) begin
        big_q   <= operands_i.second_value;
        small_q <= operands_i.first_value;
      end else begin
        big_q   <= operands_i.first_value;
        small_q <= operands_i.second_value;
      end
      count_q <= '0;
    end else if (cmd_i.step) begin
      if (count_q != CountMax) begin
        count_q <= count_q + 1'b1;
      end
      if (!rem_zero) begin
        big_q   <= small_q;
        small_q <= remainder;
      end
    end
  end

  // Status back to the controller.
  assign stat_o.small_zero = (small_q == '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.rem_zero   = rem_zero;

  // With a zero smaller operand the answer is the larger one.
  assign result_o.divisor      = (small_q == '0) ? big_q : small_q;
  assign result_o.modulo_count = count_q;

endmodule

### hw/rtl/egsc_ctrl.sv
// Controller state machine sequencing the Euclid rounds.
// Depends on egsc_pkg.
module egsc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  output logic                 done_o,
  input  egsc_pkg::egsc_stat_t stat_i,
  output egsc_pkg::egsc_cmd_t  cmd_o
);
  import egsc_pkg::*;

  egsc_state_e state_q;
  egsc_state_e state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat_i.small_zero) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          if (stat_i.rem_zero) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    busy            = 1'b1;
    done_o          = 1'b0;
    cmd_o.load      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.step      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      ST_CHECK: begin
        cmd_o.div_start = !stat_i.small_zero;
      end
      ST_DIV: begin
        cmd_o.step = stat_i.div_done;
      end
      ST_DONE: begin
        done_o = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

### test/tb_top.sv
// Self-checking testbench for the Euclid GCD step counter top level.
// Depends on egsc_pkg and euclid_gcd_step_count_top; needs no other file.
// A table of directed operand pairs is followed by random pairs, all checked in order.
module tb_top;
  import egsc_pkg::*;

  // Run limits and handy operand values.
  localparam int unsigned  RandomItems = 400;
  localparam int unsigned  QuietItems  = 60;
  localparam int unsigned  DrainCycles = 40;
  localparam longint       CycleLimit  = 3_000_000;
  localparam operand_t     MaxOperand  = '1;
  localparam operand_t     Fib46       = 31'd1836311903;
  localparam operand_t     Fib45       = 31'd1134903170;

  // One row of the directed table; the literal result is used only where has_literal is set.
  typedef struct packed {
    operand_t first_value;
    operand_t second_value;
    logic     has_literal;
    operand_t divisor;
    count_t   modulo_count;
  } gcd_row_t;

  localparam int unsigned DirectedRows = 16;
  localparam gcd_row_t DirectedTable [DirectedRows] = '{
    '{31'd0,          31'd0,          1'b1, 31'd0,          6'd0},
    '{MaxOperand,     31'd0,          1'b1, MaxOperand,     6'd0},
    '{31'd0,          31'd1,          1'b1, 31'd1,          6'd0},
    '{31'd1,          31'd1,          1'b1, 31'd1,          6'd1},
    '{MaxOperand,     MaxOperand,     1'b1, MaxOperand,     6'd1},
    '{31'd1,          MaxOperand,     1'b1, 31'd1,          6'd1},
    '{MaxOperand,     31'd1,          1'b1, 31'd1,          6'd1},
    '{31'h4000_0000,  31'h2000_0000,  1'b1, 31'h2000_0000,  6'd1},
    '{31'd123456,     31'd123456,     1'b1, 31'd123456,     6'd1},
    '{31'h2AAA_AAAA,  31'h5555_5555,  1'b0, 31'd0,          6'd0},
    '{31'd18,         31'd12,         1'b0, 31'd0,          6'd0},
    '{31'd12,         31'd18,         1'b0, 31'd0,          6'd0},
    '{Fib46,          Fib45,          1'b0, 31'd0,          6'd0},
    '{Fib45,          Fib46,          1'b0, 31'd0,          6'd0},
    '{31'd2147483646, MaxOperand,     1'b0, 31'd0,          6'd0},
    '{31'd1073741824, 31'd3,          1'b0, 31'd0,          6'd0}
  };

  logic       clk_i;
  logic       rst_ni     = 1'b0;
  logic       start      = 1'b0;
  egsc_in_t   operands_i = '0;
  logic       busy;
  logic       done_o;
  egsc_out_t  result_o;

  // Results still owed by the block, oldest first.
  egsc_out_t  pending_gcd_q [$];
  int unsigned mismatch_count = 0;
  longint     cycle_count    = 0;

  euclid_gcd_step_count_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operands_i (operands_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Greatest common divisor and the number of modulo rounds, with the count saturating.
  function automatic egsc_out_t euclid_gcd_count(input operand_t a, input operand_t b);
    operand_t  larger;
    operand_t  smaller;
    operand_t  remainder;
    count_t    rounds;
    logic      finished;
    egsc_out_t outcome;
    larger   = a;
    smaller  = b;
    rounds   = '0;
    finished = 1'b0;
    if (larger < smaller) begin
      larger  = b;
      smaller = a;
    end
    if (smaller == '0) begin
      outcome.divisor = larger;
    end else begin
      while (!finished) begin
        remainder = larger % smaller;
        if (rounds != CountMax) rounds = rounds + 1'b1;
        if (remainder == '0) begin
          finished = 1'b1;
        end else begin
          larger  = smaller;
          smaller = remainder;
        end
      end
      outcome.divisor = smaller;
    end
    outcome.modulo_count = rounds;
    return outcome;
  endfunction

  // Consecutive Fibonacci numbers give the longest chains of rounds.
  function automatic egsc_in_t fibonacci_pair(input int unsigned steps);
    longint lower;
    longint upper;
    longint next_term;
    egsc_in_t pair;
    lower = 1;
    upper = 1;
    for (int unsigned i = 0; i < steps; i++) begin
      next_term = lower + upper;
      lower     = upper;
      upper     = next_term;
    end
    pair.first_value  = operand_t'(upper);
    pair.second_value = operand_t'(lower);
    return pair;
  endfunction

  // Random operand pair: mostly full-width, with short, long, shared-factor and zero cases.
  function automatic egsc_in_t random_operands();
    egsc_in_t    pair;
    operand_t    factor;
    operand_t    swap_hold;
    pair.first_value  = operand_t'($urandom());
    pair.second_value = operand_t'($urandom());
    case ($urandom_range(0, 19))
      0: begin
        if ($urandom_range(0, 3) == 0) pair.first_value = '0;
        else if ($urandom_range(0, 1) == 1) pair.first_value = '0;
        else pair.second_value = '0;
        if ($urandom_range(0, 7) == 0) pair.second_value = '0;
      end
      1, 2: begin
        pair = fibonacci_pair($urandom_range(0, 44));
      end
      3, 4, 5: begin
        pair.first_value  = operand_t'($urandom_range(1, 1000));
        pair.second_value = operand_t'($urandom_range(1, 1000));
      end
      6, 7, 8: begin
        factor            = operand_t'($urandom_range(1, 65535));
        pair.first_value  = factor * operand_t'($urandom_range(1, 32767));
        pair.second_value = factor * operand_t'($urandom_range(1, 32767));
      end
      9: begin
        pair.second_value = pair.first_value;
      end
      default: begin
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      swap_hold         = pair.first_value;
      pair.first_value  = pair.second_value;
      pair.second_value = swap_hold;
    end
    return pair;
  endfunction

  // Present one transaction, with an optional idle burst first, and wait until it is taken.
  task automatic issue_operands(input egsc_in_t pair, input egsc_out_t wanted,
                                input logic allow_idle);
    int unsigned idle_cycles;
    logic        idle_to_end;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      idle_cycles = $urandom_range(1, 6);
      idle_to_end = 1'($urandom_range(0, 1));
      start <= 1'b0;
      repeat (idle_cycles) @(posedge clk_i);
      if (idle_to_end) begin
        while (busy) @(posedge clk_i);
      end
    end
    start      <= 1'b1;
    operands_i <= pair;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_gcd_q.push_back(wanted);
  endtask

  // Stimulus: reset, the directed table, then random pairs, then drain.
  initial begin
    egsc_in_t  pair;
    egsc_out_t wanted;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned row = 0; row < DirectedRows; row++) begin
      pair.first_value  = DirectedTable[row].first_value;
      pair.second_value = DirectedTable[row].second_value;
      if (DirectedTable[row].has_literal) begin
        wanted.divisor      = DirectedTable[row].divisor;
        wanted.modulo_count = DirectedTable[row].modulo_count;
      end else begin
        wanted = euclid_gcd_count(pair.first_value, pair.second_value);
      end
      issue_operands(pair, wanted, 1'b1);
    end

    for (int unsigned item = 0; item < RandomItems; item++) begin
      pair   = random_operands();
      wanted = euclid_gcd_count(pair.first_value, pair.second_value);
      issue_operands(pair, wanted, item < RandomItems - QuietItems);
    end
    start <= 1'b0;

    while (pending_gcd_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Result checking: every strobe must match the oldest owed result.
  always @(posedge clk_i) begin
    egsc_out_t wanted;
    if (rst_ni && done_o) begin
      if (pending_gcd_q.size() == 0) begin
        $error("result transaction with none outstanding: divisor %0d, modulo_count %0d",
               result_o.divisor, result_o.modulo_count);
        mismatch_count++;
      end else begin
        wanted = pending_gcd_q.pop_front();
        if (result_o.divisor !== wanted.divisor) begin
          $error("divisor: expected %0d, got %0d", wanted.divisor, result_o.divisor);
          mismatch_count++;
        end
        if (result_o.modulo_count !== wanted.modulo_count) begin
          $error("modulo_count: expected %0d, got %0d",
                 wanted.modulo_count, result_o.modulo_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/egsc_pkg.sv
hw/rtl/egsc_rem.sv
hw/rtl/egsc_dp.sv
hw/rtl/egsc_ctrl.sv
hw/rtl/euclid_gcd_step_count_top.sv
test/tb_top.sv
